// File: rtl/core/rigid_point_transform_macros.svh
// Assertion macros for the rigid point transform checker.
// Included by the checker file; depends on nothing else.
`ifndef RIGID_POINT_TRANSFORM_MACROS_SVH
`define RIGID_POINT_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rpt_pkg.sv
// Shared types and constants for the rigid point transform.
// No dependencies; imported by every module of the block.
package rpt_pkg;

   localparam int COORD_W    = 32;           // width of a result coordinate
   localparam int IN_W       = 32;           // width of an input coordinate
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int RE_W       = 33;           // rotation entry, range [-2^31, 2^31]
   localparam int TERM_W     = RE_W + IN_W - 14;
   localparam int SUM_W      = 54;
   localparam int V_W        = SUM_W - 16;   // rounded coordinate before saturation

   localparam int NUM_STAGES = 5;
   localparam int STG_QPROD  = 0;
   localparam int STG_ROT    = 1;
   localparam int STG_MUL    = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_SAT    = 4;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUAT_W,
      CSR_QUAT_X,
      CSR_QUAT_Y,
      CSR_QUAT_Z,
      CSR_OFFSET_X,
      CSR_OFFSET_Y,
      CSR_OFFSET_Z
   } csr_idx_type;

   typedef logic signed [RE_W-1:0] entry_type;

   typedef struct packed {
      logic signed [IN_W-1:0] point_x;
      logic signed [IN_W-1:0] point_y;
      logic signed [IN_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] moved_x;
      logic signed [COORD_W-1:0] moved_y;
      logic signed [COORD_W-1:0] moved_z;
      logic                      overflow;
   } rsp_type;

   // Load enables of the three stages inside a coordinate lane.
   typedef struct packed {
      logic mul;
      logic sum;
      logic sat;
   } pipe_en_type;

endpackage

// File: rtl/core/rpt_lane.sv
// One output coordinate: dot product of a rotation row with the point,
// plus offset, rounding and saturation. Depends on rpt_pkg.
module rpt_lane (
   input  logic                            clock,
   input  rpt_pkg::pipe_en_type            en,
   input  rpt_pkg::entry_type              row [3],
   input  rpt_pkg::req_type                point,
   input  logic signed [rpt_pkg::IN_W-1:0] offset,
   output logic signed [rpt_pkg::COORD_W-1:0] moved,
   output logic                            ovf
);
   import rpt_pkg::*;

   logic signed [IN_W-1:0]     pt [3];
   logic signed [RE_W+IN_W-1:0] prod [3];
   logic signed [TERM_W-1:0]   term_in [3];
   logic signed [TERM_W-1:0]   term_ff [3];
   logic signed [SUM_W-1:0]    sum;
   logic signed [V_W-1:0]      v_in;
   logic signed [V_W-1:0]      v_ff;
   logic signed [COORD_W-1:0]  moved_in;
   logic                       ovf_in;
   logic signed [COORD_W-1:0]  moved_ff;
   logic                       ovf_ff;

   // Each product is floored by 2^14 by dropping its low bits.
   always_comb begin
      pt[0] = point.point_x;
      pt[1] = point.point_y;
      pt[2] = point.point_z;
      for (int j = 0; j < 3; j++) begin
         prod[j]    = (RE_W+IN_W)'(row[j]) * (RE_W+IN_W)'(pt[j]);
         term_in[j] = prod[j][RE_W+IN_W-1:14];
      end
   end

   // Sum in units of 2^-32, then round half up to Q16.16.
   always_comb begin
      sum = SUM_W'(term_ff[0]) + SUM_W'(term_ff[1]) + SUM_W'(term_ff[2])
          + (SUM_W'(offset) <<< 16) + SUM_W'(32768);
      v_in = sum[SUM_W-1:16];
   end

   generate
      if (COORD_W < V_W) begin : g_sat
         localparam logic signed [V_W-1:0] HI = V_W'(COORD_MAX);
         localparam logic signed [V_W-1:0] LO = V_W'(COORD_MIN);
         always_comb begin
            ovf_in = (v_ff > HI) || (v_ff < LO);
            if (v_ff > HI) begin
               moved_in = COORD_MAX;
            end else if (v_ff < LO) begin
               moved_in = COORD_MIN;
            end else begin
               moved_in = v_ff[COORD_W-1:0];
            end
         end
      end else begin : g_wide
         always_comb begin
            ovf_in   = 1'b0;
            moved_in = COORD_W'(v_ff);
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en.mul) begin
         term_ff <= term_in;
      end
      if (en.sum) begin
         v_ff <= v_in;
      end
      if (en.sat) begin
         moved_ff <= moved_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign moved = moved_ff;
   assign ovf   = ovf_ff;

endmodule

// File: rtl/core/rigid_point_transform.sv
// Top level of the rigid point transform: configuration registers,
// quaternion-to-matrix stages and pipeline control. Depends on rpt_pkg, rpt_lane.
//
// Usage:
//   Points enter on the req_ channel (valid/ready); each accepted transaction
//   carries one point in signed Q16.16. Exactly one result transaction leaves
//   on the rsp_ channel per point, in order, holding the rotated and offset
//   point, saturated to the coordinate range, with a flag set when any
//   coordinate saturated.
//   The csr_ port writes one register per cycle at csr_index (0..3 quaternion
//   w, x, y, z in Q2.30, 4..6 offset x, y, z in Q16.16); index 7 is ignored.
//   The user must write registers only while no point is in flight; the block
//   itself does not enforce this. Each point passes through five register
//   stages: quaternion products, rotation matrix, row-times-point products,
//   sum with offset and rounding, and saturation.
//   Throughput is one point per cycle while the receiver keeps up.
//   When the receiver stalls, the result holds on rsp_ and earlier stages
//   keep moving into empty slots, so new points are still taken until the
//   pipeline is full; req_ready then drops until the receiver takes data.
//   Reset clears all stage valid bits and loads the identity rotation with
//   zero offset.
module rigid_point_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rpt_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rpt_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [rpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpt_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import rpt_pkg::*;

   localparam int QR_W = 34;   // rounded quaternion product
   localparam int ME_W = 37;   // matrix entry before clamping
   localparam logic signed [ME_W-1:0] ME_ONE = ME_W'(64'sd1073741824);
   localparam logic signed [ME_W-1:0] ME_LIM = ME_W'(64'sd2147483648);

   // Q4.60 product rounded half up to Q2.30.
   function automatic logic signed [QR_W-1:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[QR_W+29:30];
   endfunction

   function automatic entry_type clamp_entry(input logic signed [ME_W-1:0] v);
      logic signed [ME_W-1:0] c;
      c = v;
      if (v > ME_LIM) begin
         c = ME_LIM;
      end else if (v < -ME_LIM) begin
         c = -ME_LIM;
      end
      return c[RE_W-1:0];
   endfunction

   // Configuration registers.
   logic signed [CSR_DATA_W-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic signed [CSR_DATA_W-1:0] offset_x_ff, offset_y_ff, offset_z_ff;

   // Pipeline control.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_ready;
   pipe_en_type           lane_en;

   // Stage 0: raw quaternion products and the point.
   logic signed [63:0] p_xx_in, p_yy_in, p_zz_in, p_xy_in, p_xz_in;
   logic signed [63:0] p_yz_in, p_wx_in, p_wy_in, p_wz_in;
   logic signed [63:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff;
   logic signed [63:0] p_yz_ff, p_wx_ff, p_wy_ff, p_wz_ff;
   req_type            pt0_ff;

   // Stage 1: rotation matrix and the point.
   logic signed [QR_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   entry_type              rot_in [3][3];
   entry_type              rot_ff [3][3];
   req_type                pt1_ff;

   logic signed [COORD_W-1:0] moved [3];
   logic                      ovf [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff   <= CSR_DATA_W'(32'sd1073741824);
         quat_x_ff   <= '0;
         quat_y_ff   <= '0;
         quat_z_ff   <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_QUAT_W:   quat_w_ff   <= csr_write_data;
            CSR_QUAT_X:   quat_x_ff   <= csr_write_data;
            CSR_QUAT_Y:   quat_y_ff   <= csr_write_data;
            CSR_QUAT_Z:   quat_z_ff   <= csr_write_data;
            CSR_OFFSET_X: offset_x_ff <= csr_write_data;
            CSR_OFFSET_Y: offset_y_ff <= csr_write_data;
            CSR_OFFSET_Z: offset_z_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   // The ready chain runs from the output back to the input, so bubbles
   // are squeezed out while the receiver stalls.
   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (stage_ready & valid_in) | (~stage_ready & valid_ff);
      end
   end

   assign req_ready   = stage_ready[STG_QPROD];
   assign rsp_valid   = valid_ff[STG_SAT];
   assign lane_en.mul = stage_ready[STG_MUL];
   assign lane_en.sum = stage_ready[STG_SUM];
   assign lane_en.sat = stage_ready[STG_SAT];

   // The quaternion is read with the point it applies to; the user must not change
   // the registers while any point is in flight, which the block does not enforce.
   always_comb begin
      p_xx_in = 64'(quat_x_ff) * 64'(quat_x_ff);
      p_yy_in = 64'(quat_y_ff) * 64'(quat_y_ff);
      p_zz_in = 64'(quat_z_ff) * 64'(quat_z_ff);
      p_xy_in = 64'(quat_x_ff) * 64'(quat_y_ff);
      p_xz_in = 64'(quat_x_ff) * 64'(quat_z_ff);
      p_yz_in = 64'(quat_y_ff) * 64'(quat_z_ff);
      p_wx_in = 64'(quat_w_ff) * 64'(quat_x_ff);
      p_wy_in = 64'(quat_w_ff) * 64'(quat_y_ff);
      p_wz_in = 64'(quat_w_ff) * 64'(quat_z_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_QPROD]) begin
         p_xx_ff <= p_xx_in;
         p_yy_ff <= p_yy_in;
         p_zz_ff <= p_zz_in;
         p_xy_ff <= p_xy_in;
         p_xz_ff <= p_xz_in;
         p_yz_ff <= p_yz_in;
         p_wx_ff <= p_wx_in;
         p_wy_ff <= p_wy_in;
         p_wz_ff <= p_wz_in;
         pt0_ff  <= req_data;
      end
   end

   // Standard unit-quaternion rotation matrix, each entry clamped to
   // [-2^31, 2^31] in case the quaternion is not normalized.
   always_comb begin
      xx = round_q30(p_xx_ff);
      yy = round_q30(p_yy_ff);
      zz = round_q30(p_zz_ff);
      xy = round_q30(p_xy_ff);
      xz = round_q30(p_xz_ff);
      yz = round_q30(p_yz_ff);
      wx = round_q30(p_wx_ff);
      wy = round_q30(p_wy_ff);
      wz = round_q30(p_wz_ff);
      rot_in[0][0] = clamp_entry(ME_ONE - ((ME_W'(yy) + ME_W'(zz)) <<< 1));
      rot_in[0][1] = clamp_entry((ME_W'(xy) - ME_W'(wz)) <<< 1);
      rot_in[0][2] = clamp_entry((ME_W'(xz) + ME_W'(wy)) <<< 1);
      rot_in[1][0] = clamp_entry((ME_W'(xy) + ME_W'(wz)) <<< 1);
      rot_in[1][1] = clamp_entry(ME_ONE - ((ME_W'(xx) + ME_W'(zz)) <<< 1));
      rot_in[1][2] = clamp_entry((ME_W'(yz) - ME_W'(wx)) <<< 1);
      rot_in[2][0] = clamp_entry((ME_W'(xz) - ME_W'(wy)) <<< 1);
      rot_in[2][1] = clamp_entry((ME_W'(yz) + ME_W'(wx)) <<< 1);
      rot_in[2][2] = clamp_entry(ME_ONE - ((ME_W'(xx) + ME_W'(yy)) <<< 1));
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_ROT]) begin
         rot_ff <= rot_in;
         pt1_ff <= pt0_ff;
      end
   end

   // One lane per output coordinate; each covers the last three stages.
   rpt_lane u_lane_x (
      .clock  (clock),
      .en     (lane_en),
      .row    (rot_ff[0]),
      .point  (pt1_ff),
      .offset (offset_x_ff),
      .moved  (moved[0]),
      .ovf    (ovf[0])
   );

   rpt_lane u_lane_y (
      .clock  (clock),
      .en     (lane_en),
      .row    (rot_ff[1]),
      .point  (pt1_ff),
      .offset (offset_y_ff),
      .moved  (moved[1]),
      .ovf    (ovf[1])
   );

   rpt_lane u_lane_z (
      .clock  (clock),
      .en     (lane_en),
      .row    (rot_ff[2]),
      .point  (pt1_ff),
      .offset (offset_z_ff),
      .moved  (moved[2]),
      .ovf    (ovf[2])
   );

   always_comb begin
      rsp_data.moved_x  = moved[0];
      rsp_data.moved_y  = moved[1];
      rsp_data.moved_z  = moved[2];
      rsp_data.overflow = ovf[0] | ovf[1] | ovf[2];
   end

endmodule

// File: rtl/core/rpt_checker.sv
// Port-level checks for the rigid point transform, bound to the top level.
// Depends on rpt_pkg and rigid_point_transform_macros.svh.
`include "rigid_point_transform_macros.svh"

module rpt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input rpt_pkg::rsp_type               rsp_data
);
   import rpt_pkg::*;

   logic x_on_bound;
   logic y_on_bound;
   logic z_on_bound;

   assign x_on_bound = (rsp_data.moved_x == COORD_MAX) || (rsp_data.moved_x == COORD_MIN);
   assign y_on_bound = (rsp_data.moved_y == COORD_MAX) || (rsp_data.moved_y == COORD_MIN);
   assign z_on_bound = (rsp_data.moved_z == COORD_MAX) || (rsp_data.moved_z == COORD_MIN);

   // A stalled result holds its value.
   `RPT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_data), "stalled result changed")

   // With the output slot free or draining, the whole pipeline can advance.
   `RPT_ASSERT_IMP(a_ready_when_drain, clock, reset, !rsp_valid || rsp_ready,
                   req_ready, "input blocked while output drains")

   // Nothing comes out right after reset.
   `RPT_ASSERT_IMP(a_empty_after_reset, clock, reset, $past(reset),
                   !rsp_valid, "result present right after reset")

   // A saturated result has at least one coordinate on a bound.
   `RPT_ASSERT_IMP(a_ovf_on_bound, clock, reset, rsp_valid && rsp_data.overflow,
                   x_on_bound || y_on_bound || z_on_bound,
                   "overflow without a saturated coordinate")

endmodule

bind rigid_point_transform rpt_checker u_rpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data       (rsp_data)
);
